[design/xbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xbt_pkg
// Command and status codes of the xor binary trie multiset.
// ----------------------------------------------------------------------------
package xbt_pkg;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_ERASE = 3'd1,
		CMD_COUNT = 3'd2,
		CMD_KTH   = 3'd3,
		CMD_MIN   = 3'd4,
		CMD_MAX   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

endpackage
`default_nettype wire

[design/xbt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xbt_if
// Valid/ready channels for commands and results of the trie multiset.
// ----------------------------------------------------------------------------
interface xbt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] key_value;
	logic [31:0] xor_mask;
	logic [31:0] rank;

	modport source (output valid, cmd, key_value, xor_mask, rank, input ready);
	modport sink (input valid, cmd, key_value, xor_mask, rank, output ready);
endinterface

interface xbt_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] found_value;
	logic [31:0] key_count;
	logic [1:0]  status;

	modport source (output valid, found_value, key_count, status, input ready);
	modport sink (input valid, found_value, key_count, status, output ready);
endinterface
`default_nettype wire

[design/xor_binary_trie_multiset.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_binary_trie_multiset
// Multiset of keys held as a binary trie in a node pool memory, with
// add, erase, count, k-th smallest, min and max under an xor mask.
//
//   channel  dir  word
//   req      in   cmd, key_value, xor_mask, rank
//   rsp      out  found_value, key_count, status
//
// one command at a time; each walk makes one node memory read per trie level
// plus a second read where the walk turns. the root node lives in registers,
// so reset clears the pool at once.
// a finished word waits in the output register while the next command runs.
// ----------------------------------------------------------------------------
module xor_binary_trie_multiset
	import xbt_pkg::*;
#(
	parameter int KEY_BITS   = 32,
	parameter int POOL_NODES = 4096,
	parameter int COUNT_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	xbt_req_if.sink   req,
	xbt_rsp_if.source rsp
);

	localparam int NW = $clog2(POOL_NODES);
	localparam int LW = $clog2(KEY_BITS + 1);
	localparam int KW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam logic [NW:0] FP_LIMIT = (NW+1)'(POOL_NODES - KEY_BITS);
	localparam int DW = 2 * NW + COUNT_BITS;

	typedef struct packed {
		logic [NW-1:0]         left;
		logic [NW-1:0]         right;
		logic [COUNT_BITS-1:0] cnt;
	} node_t;

	typedef enum logic [3:0] {
		S_IDLE, S_UPD, S_UPDW, S_FIND, S_FINDW, S_KF, S_KR, S_KW, S_DONE
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	status_t             status_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] path_q;
	logic [KEY_BITS-1:0] mask_q;
	logic [KEY_BITS-1:0] res_q;
	logic [KW-1:0]       k_q;
	logic [LW-1:0]       lvl_q;
	logic [NW-1:0]       node_q;
	logic [NW:0]         fp_q;
	node_t               cur_q;
	node_t               root_q;
	logic                up_q;
	logic                zc_q;
	logic [COUNT_BITS-1:0] kc_q;

	logic                out_valid_q;
	logic [31:0]         out_found_q;
	logic [31:0]         out_count_q;
	status_t             out_status_q;

	logic [63:0] key64, mask64, rank64;
	logic [KEY_BITS-1:0] in_mask, in_path;
	logic          cur_bit, fbit, lvl_zero, take_other;
	logic [NW-1:0] child, kchild, kother;
	logic [COUNT_BITS-1:0] cnt_upd;
	node_t         upd_node, rd_node;
	logic [DW-1:0] rd_data;
	logic          rd_en, wr_en;
	logic [NW-1:0] rd_addr;
	logic [KW-1:0] rd_cnt_ext, total_ext, k_in;
	logic [63:0]   res64, kc64, root64;
	cmd_t          in_cmd;

	assign key64   = {32'd0, req.key_value};
	assign mask64  = {32'd0, req.xor_mask};
	assign rank64  = {32'd0, req.rank};
	assign in_mask = mask64[KEY_BITS-1:0];
	assign in_path = key64[KEY_BITS-1:0] ^ in_mask;
	assign in_cmd  = cmd_t'(req.cmd);

	assign cur_bit  = path_q[KEY_BITS-1];
	assign fbit     = mask_q[KEY_BITS-1];
	assign lvl_zero = (lvl_q == '0);
	assign child    = cur_bit ? cur_q.right : cur_q.left;
	assign kchild   = fbit ? cur_q.right : cur_q.left;
	assign kother   = fbit ? cur_q.left : cur_q.right;
	assign cnt_upd  = up_q ? cur_q.cnt + 1'b1 : cur_q.cnt - 1'b1;
	assign rd_node  = node_t'(rd_data);
	assign rd_cnt_ext = KW'(rd_node.cnt);
	assign total_ext  = KW'(root_q.cnt);
	assign take_other = zc_q || (rd_cnt_ext < k_q);

	always_comb begin
		unique case (in_cmd)
			CMD_KTH: k_in = rank64[KW-1:0];
			CMD_MIN: k_in = KW'(1);
			default: k_in = total_ext;
		endcase
	end

	always_comb begin
		upd_node     = cur_q;
		upd_node.cnt = cnt_upd;
		if (!lvl_zero && child == '0) begin
			if (cur_bit) begin
				upd_node.right = fp_q[NW-1:0];
			end else begin
				upd_node.left = fp_q[NW-1:0];
			end
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = child;
		wr_en   = (state_q == S_UPD) && (node_q != '0);
		case (state_q)
			S_UPD, S_FIND: rd_en = !lvl_zero && (child != '0);
			S_KF: begin
				rd_en   = !lvl_zero && (kchild != '0);
				rd_addr = kchild;
			end
			S_KR: begin
				rd_en   = take_other && (kother != '0);
				rd_addr = kother;
			end
			default: rd_en = 1'b0;
		endcase
	end

	xbt_node_ram #(
		.DATA_W(DW),
		.ADDR_W(NW),
		.DEPTH (POOL_NODES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(node_q),
		.wr_data(DW'(upd_node)),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign res64  = 64'(res_q);
	assign kc64   = 64'(kc_q);
	assign root64 = 64'(root_q.cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fp_q         <= (NW+1)'(1);
			root_q       <= '0;
			out_valid_q  <= 1'b0;
			cmd_q        <= CMD_ADD;
			status_q     <= ST_OK;
			out_status_q <= ST_OK;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= in_cmd;
						key_q    <= in_path;
						path_q   <= in_path;
						mask_q   <= in_mask;
						res_q    <= '0;
						k_q      <= k_in;
						lvl_q    <= LW'(KEY_BITS);
						node_q   <= '0;
						cur_q    <= root_q;
						zc_q     <= 1'b0;
						status_q <= ST_OK;
						up_q     <= (in_cmd == CMD_ADD);
						case (in_cmd)
							CMD_ADD: begin
								if (fp_q > FP_LIMIT) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_UPD;
								end
							end
							CMD_ERASE, CMD_COUNT: state_q <= S_FIND;
							CMD_KTH, CMD_MIN, CMD_MAX: begin
								if (k_in == '0 || k_in > total_ext) begin
									status_q <= ST_RANGE;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_KF;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_UPD: begin
					if (node_q == '0) begin
						root_q <= upd_node;
					end
					if (lvl_zero) begin
						state_q <= S_DONE;
					end else begin
						lvl_q  <= lvl_q - 1'b1;
						path_q <= path_q << 1;
						if (child == '0) begin
							node_q <= fp_q[NW-1:0];
							fp_q   <= fp_q + 1'b1;
							cur_q  <= '0;
						end else begin
							node_q  <= child;
							state_q <= S_UPDW;
						end
					end
				end
				S_UPDW: begin
					cur_q   <= rd_node;
					state_q <= S_UPD;
				end
				S_FIND: begin
					if (lvl_zero) begin
						kc_q <= cur_q.cnt;
						if (cmd_q == CMD_COUNT) begin
							state_q <= S_DONE;
						end else if (cur_q.cnt == '0) begin
							status_q <= ST_ABSENT;
							state_q  <= S_DONE;
						end else begin
							path_q  <= key_q;
							lvl_q   <= LW'(KEY_BITS);
							node_q  <= '0;
							cur_q   <= root_q;
							state_q <= S_UPD;
						end
					end else if (child == '0) begin
						kc_q <= '0;
						if (cmd_q == CMD_ERASE) begin
							status_q <= ST_ABSENT;
						end
						state_q <= S_DONE;
					end else begin
						lvl_q   <= lvl_q - 1'b1;
						path_q  <= path_q << 1;
						state_q <= S_FINDW;
					end
				end
				S_FINDW: begin
					cur_q   <= rd_node;
					state_q <= S_FIND;
				end
				S_KF: begin
					if (lvl_zero) begin
						state_q <= S_DONE;
					end else begin
						zc_q    <= (kchild == '0);
						state_q <= S_KR;
					end
				end
				S_KR: begin
					zc_q   <= 1'b0;
					lvl_q  <= lvl_q - 1'b1;
					mask_q <= mask_q << 1;
					if (take_other) begin
						k_q   <= k_q - (zc_q ? '0 : rd_cnt_ext);
						res_q <= (res_q << 1) | KEY_BITS'(1);
						if (kother == '0) begin
							cur_q   <= root_q;
							state_q <= S_KF;
						end else begin
							state_q <= S_KW;
						end
					end else begin
						res_q   <= res_q << 1;
						cur_q   <= rd_node;
						state_q <= S_KF;
					end
				end
				S_KW: begin
					cur_q   <= rd_node;
					state_q <= S_KF;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_found_q  <= res64[31:0];
						out_count_q  <= (cmd_q == CMD_COUNT) ? kc64[31:0] : root64[31:0];
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.found_value = out_found_q;
	assign rsp.key_count   = out_count_q;
	assign rsp.status      = out_status_q;

endmodule
`default_nettype wire

[design/xbt_node_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xbt_node_ram
// Node pool memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module xbt_node_ram #(
	parameter int DATA_W = 56,
	parameter int ADDR_W = 12,
	parameter int DEPTH  = 4096
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire
